// ===== design/date_validate_day_number_unit_defines.svh =====
// Assertion macros for the date validation design files.
`ifndef DATE_VALIDATE_DAY_NUMBER_UNIT_DEFINES_SVH
`define DATE_VALIDATE_DAY_NUMBER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DVDN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DVDN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dvdn_pkg.sv =====
// Types, constants and calendar tables for the date validation unit.
package dvdn_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned DayNumW = 22;

  localparam logic [YearW-1:0] YearCeiling   = 14'd9999;
  localparam logic [YearW-1:0] FirstYearRst  = 14'd1500;
  localparam logic [YearW-1:0] CurYearRst    = 14'd2022;
  localparam logic [DayNumW-1:0] DayNumMax   = 22'd3652059;

  // Reciprocal of 100 scaled by 2^19, exact for years up to the ceiling.
  localparam logic [12:0] Recip100 = 13'd5243;

  localparam logic CfgFirstYear = 1'b0;
  localparam logic CfgCurYear   = 1'b1;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StYear  = 2'd1,
    StMonth = 2'd2,
    StDay   = 2'd3
  } status_e;

  typedef struct packed {
    status_e              status;
    logic [DayNumW-1:0]   day_number;
  } res_t;

  // Length of a month; months outside 1 to 12 give 0.
  function automatic logic [DayW-1:0] month_len(logic [MonthW-1:0] m, logic leap);
    logic [DayW-1:0] n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // Days before the month in a year that starts in March.
  function automatic logic [8:0] month_offset(logic [MonthW-1:0] m);
    logic [8:0] n;
    unique case (m)
      4'd3:    n = 9'd0;
      4'd4:    n = 9'd31;
      4'd5:    n = 9'd61;
      4'd6:    n = 9'd92;
      4'd7:    n = 9'd122;
      4'd8:    n = 9'd153;
      4'd9:    n = 9'd184;
      4'd10:   n = 9'd214;
      4'd11:   n = 9'd245;
      4'd12:   n = 9'd275;
      4'd1:    n = 9'd306;
      4'd2:    n = 9'd337;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== design/dvdn_calc.sv =====
// Date checks and day number calculation between the input and result registers.
module dvdn_calc (
  input  logic [dvdn_pkg::YearW-1:0]  year_i,
  input  logic [dvdn_pkg::MonthW-1:0] month_i,
  input  logic [dvdn_pkg::DayW-1:0]   day_i,
  input  logic [dvdn_pkg::YearW-1:0]  first_year_i,
  input  logic [dvdn_pkg::YearW-1:0]  current_year_i,
  output dvdn_pkg::res_t              res_o
);

  logic [dvdn_pkg::YearW-1:0]   ty;
  logic [26:0]                  prod_y;
  logic [26:0]                  prod_t;
  logic [7:0]                   qy;
  logic [7:0]                   qt;
  logic                         div100;
  logic                         leap;
  logic                         year_bad;
  logic                         month_bad;
  logic                         day_bad;
  logic [dvdn_pkg::DayNumW-1:0] dn;

  assign ty = (month_i < 4'd3) ? year_i - 14'd1 : year_i;

  assign prod_y = 27'(year_i) * 27'(dvdn_pkg::Recip100);
  assign prod_t = 27'(ty) * 27'(dvdn_pkg::Recip100);
  assign qy     = prod_y[26:19];
  assign qt     = prod_t[26:19];

  // A multiple of 100 leaves only a small error in the fraction bits.
  assign div100 = (prod_y[18:12] == 7'd0);
  assign leap   = ((year_i[1:0] == 2'd0) && !div100) || (div100 && (qy[1:0] == 2'd0));

  assign year_bad  = (year_i == 14'd0) || (year_i > dvdn_pkg::YearCeiling) ||
                     (year_i < first_year_i) ||
                     ({1'b0, year_i} > ({1'b0, current_year_i} + 15'd1));
  assign month_bad = (month_i == 4'd0) || (month_i > 4'd12);
  assign day_bad   = (day_i == 5'd0) || (day_i > dvdn_pkg::month_len(month_i, leap));

  assign dn = 22'(ty) * 22'd365 + 22'(ty[13:2]) - 22'(qt) + 22'(qt[7:2])
            + 22'(dvdn_pkg::month_offset(month_i)) + 22'(day_i) - 22'd306;

  always_comb begin
    res_o.day_number = '0;
    priority if (year_bad) begin
      res_o.status = dvdn_pkg::StYear;
    end else if (month_bad) begin
      res_o.status = dvdn_pkg::StMonth;
    end else if (day_bad) begin
      res_o.status = dvdn_pkg::StDay;
    end else begin
      res_o.status     = dvdn_pkg::StOk;
      res_o.day_number = dn;
    end
  end

endmodule

// ===== design/date_validate_day_number_unit.sv =====
// Top level of the Gregorian date validation and day number unit.
//
// Input channel: year_i, month_i and day_i transfer when in_valid_i is high
// and in_stall_o is low. Output channel: status_o and day_number_o transfer
// when out_valid_o is high and out_stall_i is low. Every input transfer
// gives exactly one output transfer, in order.
// The lowest accepted year and the current year are written through cfg_we_i,
// cfg_idx_i and cfg_data_i, by the user only while no item is in flight; the
// block itself does not enforce this. The item is held in an input register,
// checked and converted in one pass of combinational logic, and held in a
// result register. While the receiver does not stall, one item is accepted
// every cycle; the rate is set by that single pass, with the date checks and
// three constant multiplications in parallel. When the receiver stalls, the
// result stays in the output register and the input register still takes
// one more item; only when both are full does in_stall_o rise. Reset empties
// both stages and loads the registers with 1500 and 2022.
`include "date_validate_day_number_unit_defines.svh"

module date_validate_day_number_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [dvdn_pkg::YearW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dvdn_pkg::YearW-1:0]    year_i,
  input  logic [dvdn_pkg::MonthW-1:0]   month_i,
  input  logic [dvdn_pkg::DayW-1:0]     day_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [dvdn_pkg::DayNumW-1:0]  day_number_o
);

  logic [dvdn_pkg::YearW-1:0]   first_year_q;
  logic [dvdn_pkg::YearW-1:0]   cur_year_q;
  logic                         s1_valid_q;
  logic                         s1_valid_d;
  logic [dvdn_pkg::YearW-1:0]   year_q;
  logic [dvdn_pkg::MonthW-1:0]  month_q;
  logic [dvdn_pkg::DayW-1:0]    day_q;
  logic                         out_valid_q;
  logic                         out_valid_d;
  dvdn_pkg::res_t               res_d;
  dvdn_pkg::res_t               res_q;
  logic                         in_acc;
  logic                         s1_adv;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_adv ? 1'b1 : ((out_valid_q && !out_stall_i) ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_year_q <= dvdn_pkg::FirstYearRst;
      cur_year_q   <= dvdn_pkg::CurYearRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dvdn_pkg::CfgFirstYear: first_year_q <= cfg_data_i;
        dvdn_pkg::CfgCurYear:   cur_year_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      year_q  <= year_i;
      month_q <= month_i;
      day_q   <= day_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  dvdn_calc u_calc (
    .year_i         (year_q),
    .month_i        (month_q),
    .day_i          (day_q),
    .first_year_i   (first_year_q),
    .current_year_i (cur_year_q),
    .res_o          (res_d)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = res_q.status;
  assign day_number_o = res_q.day_number;

  `DVDN_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, in_acc && s1_valid_q, s1_adv,
    "input register overwritten before its item moved on")
  `DVDN_ASSERT_IMP(a_ok_nonzero, clk_i, rst_ni, out_valid_q && (res_q.status == dvdn_pkg::StOk),
    (res_q.day_number != '0) && (res_q.day_number <= dvdn_pkg::DayNumMax),
    "valid date gave a day number out of range")
  `DVDN_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_valid_q && (res_q.status != dvdn_pkg::StOk),
    res_q.day_number == '0, "rejected date gave a nonzero day number")
  `DVDN_ASSERT_NXT(a_adv_fills_out, clk_i, rst_ni, s1_adv, out_valid_q,
    "item left the input register without reaching the output")

endmodule

// ===== tb/sv/date_validate_day_number_unit_tb.sv =====
// Self-checking testbench for the date validation and day number unit.
module date_validate_day_number_unit_tb;

  localparam int CycleLimit = 400000;
  localparam int LongHold   = 48;
  localparam int PhaseDates = 295;

  typedef enum logic {RowDate, RowReg} row_kind_e;

  // For register rows, val holds the value to write and idx the register.
  typedef struct packed {
    row_kind_e                    kind;
    logic                         idx;
    logic [dvdn_pkg::YearW-1:0]   val;
    logic [dvdn_pkg::MonthW-1:0]  month;
    logic [dvdn_pkg::DayW-1:0]    day;
    logic                         known;
    dvdn_pkg::res_t               want;
  } step_t;

  localparam dvdn_pkg::res_t NoRes = '{dvdn_pkg::StOk, 22'd0};

  step_t plan [32] = '{
    '{RowDate, 1'b0, 14'd0,     4'd1,  5'd1,  1'b1, '{dvdn_pkg::StYear, 22'd0}},
    '{RowDate, 1'b0, 14'd1499,  4'd6,  5'd15, 1'b1, '{dvdn_pkg::StYear, 22'd0}},
    '{RowDate, 1'b0, 14'd1500,  4'd1,  5'd1,  1'b0, NoRes},
    '{RowDate, 1'b0, 14'd2023,  4'd12, 5'd31, 1'b0, NoRes},
    '{RowDate, 1'b0, 14'd2024,  4'd1,  5'd1,  1'b1, '{dvdn_pkg::StYear, 22'd0}},
    '{RowDate, 1'b0, 14'd16383, 4'd15, 5'd31, 1'b1, '{dvdn_pkg::StYear, 22'd0}},
    '{RowDate, 1'b0, 14'd2000,  4'd0,  5'd10, 1'b1, '{dvdn_pkg::StMonth, 22'd0}},
    '{RowDate, 1'b0, 14'd2000,  4'd13, 5'd1,  1'b1, '{dvdn_pkg::StMonth, 22'd0}},
    '{RowDate, 1'b0, 14'd2000,  4'd15, 5'd0,  1'b1, '{dvdn_pkg::StMonth, 22'd0}},
    '{RowDate, 1'b0, 14'd2000,  4'd2,  5'd29, 1'b0, NoRes},
    '{RowDate, 1'b0, 14'd1900,  4'd2,  5'd29, 1'b1, '{dvdn_pkg::StDay, 22'd0}},
    '{RowDate, 1'b0, 14'd2020,  4'd2,  5'd29, 1'b0, NoRes},
    '{RowDate, 1'b0, 14'd2021,  4'd2,  5'd29, 1'b1, '{dvdn_pkg::StDay, 22'd0}},
    '{RowDate, 1'b0, 14'd2021,  4'd4,  5'd31, 1'b1, '{dvdn_pkg::StDay, 22'd0}},
    '{RowDate, 1'b0, 14'd2021,  4'd7,  5'd0,  1'b1, '{dvdn_pkg::StDay, 22'd0}},
    '{RowReg,  dvdn_pkg::CfgFirstYear, 14'd0,     4'd0, 5'd0, 1'b0, NoRes},
    '{RowReg,  dvdn_pkg::CfgCurYear,   14'd16383, 4'd0, 5'd0, 1'b0, NoRes},
    '{RowDate, 1'b0, 14'd1,     4'd1,  5'd1,  1'b1, '{dvdn_pkg::StOk, 22'd1}},
    '{RowDate, 1'b0, 14'd0,     4'd1,  5'd1,  1'b1, '{dvdn_pkg::StYear, 22'd0}},
    '{RowDate, 1'b0, 14'd9999,  4'd12, 5'd31, 1'b1, '{dvdn_pkg::StOk, dvdn_pkg::DayNumMax}},
    '{RowDate, 1'b0, 14'd10000, 4'd1,  5'd1,  1'b1, '{dvdn_pkg::StYear, 22'd0}},
    '{RowDate, 1'b0, 14'd16383, 4'd12, 5'd31, 1'b1, '{dvdn_pkg::StYear, 22'd0}},
    '{RowDate, 1'b0, 14'd9999,  4'd2,  5'd29, 1'b1, '{dvdn_pkg::StDay, 22'd0}},
    '{RowReg,  dvdn_pkg::CfgFirstYear, 14'd9999, 4'd0, 5'd0, 1'b0, NoRes},
    '{RowReg,  dvdn_pkg::CfgCurYear,   14'd9998, 4'd0, 5'd0, 1'b0, NoRes},
    '{RowDate, 1'b0, 14'd9999,  4'd1,  5'd1,  1'b0, NoRes},
    '{RowDate, 1'b0, 14'd9998,  4'd1,  5'd1,  1'b1, '{dvdn_pkg::StYear, 22'd0}},
    '{RowReg,  dvdn_pkg::CfgFirstYear, 14'd1, 4'd0, 5'd0, 1'b0, NoRes},
    '{RowReg,  dvdn_pkg::CfgCurYear,   14'd1, 4'd0, 5'd0, 1'b0, NoRes},
    '{RowDate, 1'b0, 14'd1,     4'd12, 5'd31, 1'b1, '{dvdn_pkg::StOk, 22'd365}},
    '{RowDate, 1'b0, 14'd2,     4'd12, 5'd31, 1'b0, NoRes},
    '{RowDate, 1'b0, 14'd3,     4'd1,  5'd1,  1'b1, '{dvdn_pkg::StYear, 22'd0}}
  };

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic                         cfg_idx = 1'b0;
  logic [dvdn_pkg::YearW-1:0]   cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [dvdn_pkg::YearW-1:0]   year = '0;
  logic [dvdn_pkg::MonthW-1:0]  month = '0;
  logic [dvdn_pkg::DayW-1:0]    day = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [1:0]                   status;
  logic [dvdn_pkg::DayNumW-1:0] day_number;

  logic [dvdn_pkg::YearW-1:0] first_year_q = dvdn_pkg::FirstYearRst;
  logic [dvdn_pkg::YearW-1:0] cur_year_q = dvdn_pkg::CurYearRst;
  dvdn_pkg::res_t             pending_results [$];
  logic                       offer_known = 1'b0;
  dvdn_pkg::res_t             offer_res = NoRes;
  bit                         jitter = 1'b1;
  bit                         hold_req = 1'b0;
  int                         stall_left = 0;
  int                         cycle_cnt = 0;
  int                         fail_count = 0;
  int                         dates_sent = 0;
  int                         reg_writes = 0;
  int                         held_off = 0;
  int                         status_tally [4] = '{0, 0, 0, 0};

  date_validate_day_number_unit u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .year_i       (year),
    .month_i      (month),
    .day_i        (day),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .day_number_o (day_number)
  );

  always #4 clk = ~clk;

  function automatic bit is_leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_days(int y, int m);
    int n;
    case (m)
      1, 3, 5, 7, 8, 10, 12: n = 31;
      4, 6, 9, 11:           n = 30;
      2:                     n = is_leap_year(y) ? 29 : 28;
      default:               n = 0;
    endcase
    return n;
  endfunction

  function automatic dvdn_pkg::res_t date_to_day_number(logic [dvdn_pkg::YearW-1:0] y,
                                                        logic [dvdn_pkg::MonthW-1:0] m,
                                                        logic [dvdn_pkg::DayW-1:0] d);
    dvdn_pkg::res_t r;
    int             ty;
    int             tm;
    r = NoRes;
    if (y == 0 || y > dvdn_pkg::YearCeiling || y < first_year_q ||
        int'(y) > int'(cur_year_q) + 1) begin
      r.status = dvdn_pkg::StYear;
    end else if (m < 1 || m > 12) begin
      r.status = dvdn_pkg::StMonth;
    end else if (d < 1 || int'(d) > month_days(int'(y), int'(m))) begin
      r.status = dvdn_pkg::StDay;
    end else begin
      ty = int'(y);
      tm = int'(m);
      if (tm < 3) begin
        ty = ty - 1;
        tm = tm + 12;
      end
      r.day_number = dvdn_pkg::DayNumW'(365 * ty + ty / 4 - ty / 100 + ty / 400
                                        + (153 * tm - 457) / 5 + int'(d) - 306);
    end
    return r;
  endfunction

  // Transfers on the input and output channels, and register writes.
  always @(posedge clk) begin
    dvdn_pkg::res_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pending_results.push_back(offer_known ? offer_res
                                              : date_to_day_number(year, month, day));
        dates_sent++;
      end
      if (in_valid && in_stall) begin
        held_off++;
      end
      if (out_valid && !out_stall) begin
        status_tally[status]++;
        if (pending_results.size() == 0) begin
          $display("%0t: result with no date pending: status %0d, day number %0d",
                   $time, status, day_number);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, status);
            fail_count++;
          end
          if (day_number !== want.day_number) begin
            $display("%0t: day number mismatch: expected %0d, got %0d",
                     $time, want.day_number, day_number);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_idx == dvdn_pkg::CfgFirstYear) begin
          first_year_q = cfg_data;
        end else begin
          cur_year_q = cfg_data;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      if (hold_req) begin
        stall_left = LongHold;
        hold_req = 1'b0;
      end else if (jitter && $urandom_range(3, 0) == 0) begin
        stall_left = $urandom_range(7, 1);
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic offer_date(logic [dvdn_pkg::YearW-1:0] y, logic [dvdn_pkg::MonthW-1:0] m,
                            logic [dvdn_pkg::DayW-1:0] d, logic known,
                            dvdn_pkg::res_t want);
    int gap;
    gap = 0;
    if (jitter && $urandom_range(3, 0) == 0) begin
      gap = $urandom_range(7, 1);
    end
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    year <= y;
    month <= m;
    day <= d;
    offer_known = known;
    offer_res = want;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [dvdn_pkg::YearW-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  // Mostly valid dates in the accepted years, some day 0 or past the month end, some noise.
  task automatic pick_date(output logic [dvdn_pkg::YearW-1:0] y,
                           output logic [dvdn_pkg::MonthW-1:0] m,
                           output logic [dvdn_pkg::DayW-1:0] d);
    int r;
    int lo;
    int hi;
    int len;
    r = $urandom_range(99, 0);
    lo = (first_year_q > 1) ? int'(first_year_q) : 1;
    hi = int'(cur_year_q) + 1;
    if (hi > 9999) begin
      hi = 9999;
    end
    if (r >= 85 || lo > hi) begin
      y = dvdn_pkg::YearW'($urandom_range(16383, 0));
      m = dvdn_pkg::MonthW'($urandom_range(15, 0));
      d = dvdn_pkg::DayW'($urandom_range(31, 0));
    end else begin
      case ($urandom_range(7, 0))
        0:       y = dvdn_pkg::YearW'(lo);
        1:       y = dvdn_pkg::YearW'(hi);
        default: y = dvdn_pkg::YearW'($urandom_range(hi, lo));
      endcase
      m = dvdn_pkg::MonthW'($urandom_range(12, 1));
      len = month_days(int'(y), int'(m));
      if (r >= 75) begin
        d = (r % 2 == 0 || len == 31) ? '0 : dvdn_pkg::DayW'($urandom_range(31, len + 1));
      end else begin
        case ($urandom_range(3, 0))
          0:       d = dvdn_pkg::DayW'(len);
          1:       d = dvdn_pkg::DayW'(1);
          default: d = dvdn_pkg::DayW'($urandom_range(len, 1));
        endcase
      end
    end
  endtask

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [dvdn_pkg::YearW-1:0]  y;
    logic [dvdn_pkg::MonthW-1:0] m;
    logic [dvdn_pkg::DayW-1:0]   d;
    logic [dvdn_pkg::YearW-1:0]  lo_cfg;
    logic [dvdn_pkg::YearW-1:0]  hi_cfg;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == RowReg) begin
        drain();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        offer_date(plan[i].val, plan[i].month, plan[i].day, plan[i].known, plan[i].want);
      end
    end

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin
          lo_cfg = 14'd1;
          hi_cfg = 14'd9998;
        end
        1: begin
          lo_cfg = 14'd0;
          hi_cfg = 14'd16383;
        end
        3: begin
          lo_cfg = 14'd9999;
          hi_cfg = 14'd9998;
        end
        5: begin
          lo_cfg = dvdn_pkg::FirstYearRst;
          hi_cfg = dvdn_pkg::CurYearRst;
        end
        default: begin
          lo_cfg = dvdn_pkg::YearW'($urandom_range(3000, 1));
          hi_cfg = dvdn_pkg::YearW'($urandom_range(9998, int'(lo_cfg)));
        end
      endcase
      write_reg(dvdn_pkg::CfgFirstYear, lo_cfg);
      write_reg(dvdn_pkg::CfgCurYear, hi_cfg);
      jitter = (p != 5);
      for (int k = 0; k < PhaseDates; k++) begin
        if (p == 2 && k == 40) begin
          jitter = 1'b0;
          hold_req = 1'b1;
        end
        if (p == 2 && k == 100) begin
          jitter = 1'b1;
        end
        pick_date(y, m, d);
        offer_date(y, m, d, 1'b0, NoRes);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      fail_count++;
    end
    $display("%0d dates checked: %0d valid, %0d bad year, %0d bad month, %0d bad day.",
             dates_sent, status_tally[dvdn_pkg::StOk], status_tally[dvdn_pkg::StYear],
             status_tally[dvdn_pkg::StMonth], status_tally[dvdn_pkg::StDay]);
    $display("%0d register writes; input held off on %0d cycles by output back-pressure.",
             reg_writes, held_off);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
